// ===== rtl/core/ansi_terminal_char_engine_core_assert.svh =====
// Assertion macros for the terminal character engine.
`ifndef ANSI_TERMINAL_CHAR_ENGINE_CORE_ASSERT_SVH
`define ANSI_TERMINAL_CHAR_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ACTE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acte assertion failed");

// Next-cycle implication.
`define ACTE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acte assertion failed");

`endif

// ===== rtl/core/acte_pkg.sv =====
// Shared constants, types and the colour palette of the terminal character engine.
`timescale 1ns / 1ps
package acte_pkg;

  // character codes
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_THREE    = 8'h33;
  localparam logic [7:0] CH_FOUR     = 8'h34;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UP       = 8'h41;
  localparam logic [7:0] CH_DOWN     = 8'h42;
  localparam logic [7:0] CH_RIGHT    = 8'h43;
  localparam logic [7:0] CH_LEFT     = 8'h44;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SGR      = 8'h6D;

  // parser phases
  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  localparam logic [1:0] PARAMS_FULL = 2'd2;
  localparam logic [3:0] DIGIT_DEFAULT_FG = 4'd7;

  // configuration register map
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DFLT_FG = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_BG = 4'd3;

  localparam logic [7:0] COLUMNS_RST = 8'd80;
  localparam logic [6:0] ROWS_RST    = 7'd25;
  localparam logic [3:0] DFLT_FG_RST = 4'd15;
  localparam logic [3:0] INIT_BG_RST = 4'd0;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 64;

  // effective screen size and colour setting seen by the engine
  typedef struct packed {
    logic [7:0] width;
    logic [6:0] height;
    logic [3:0] dflt_fg;
  } dims_t;

  typedef struct packed {
    logic       draw_valid;
    logic [6:0] cell_col;
    logic [5:0] cell_row;
    logic [7:0] glyph;
    logic [3:0] draw_fg;
    logic [3:0] draw_bg;
    logic       scroll_up;
  } result_t;

  function automatic logic [3:0] palette_lookup(input logic [3:0] digit);
    logic [3:0] colour;
    case (digit)
      4'd1:    colour = 4'd9;
      4'd2:    colour = 4'd10;
      4'd3:    colour = 4'd11;
      4'd4:    colour = 4'd12;
      4'd5:    colour = 4'd13;
      4'd6:    colour = 4'd14;
      4'd7:    colour = 4'd8;
      4'd8:    colour = 4'd15;
      default: colour = 4'd0;
    endcase
    return colour;
  endfunction

endpackage

// ===== rtl/core/acte_chr_if.sv =====
// Character input channel.
`timescale 1ns / 1ps
interface acte_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/core/acte_res_if.sv =====
// Draw/scroll result channel.
`timescale 1ns / 1ps
interface acte_res_if;
  logic       valid;
  logic       ready;
  logic       draw_valid;
  logic [6:0] cell_col;
  logic [5:0] cell_row;
  logic [7:0] glyph;
  logic [3:0] draw_fg;
  logic [3:0] draw_bg;
  logic       scroll_up;

  modport source (output valid, output draw_valid, output cell_col, output cell_row,
                  output glyph, output draw_fg, output draw_bg, output scroll_up,
                  input ready);
  modport sink (input valid, input draw_valid, input cell_col, input cell_row,
                input glyph, input draw_fg, input draw_bg, input scroll_up,
                output ready);
endinterface

// ===== rtl/core/acte_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps
interface acte_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/acte_cfg_regs.sv =====
// Configuration registers and the clamped screen size.
`timescale 1ns / 1ps
module acte_cfg_regs #(
  parameter int MAX_COLS = acte_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = acte_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [acte_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [7:0]                      wr_data,
  output acte_pkg::dims_t                 dims
);
  import acte_pkg::*;

  logic [7:0] columns;
  logic [6:0] rows;
  logic [3:0] dflt_fg;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= COLUMNS_RST;
      rows    <= ROWS_RST;
      dflt_fg <= DFLT_FG_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_COLUMNS: columns <= wr_data;
        REG_ROWS:    rows    <= wr_data[6:0];
        REG_DFLT_FG: dflt_fg <= wr_data[3:0];
        // background only matters at reset, which restores its reset value
        REG_INIT_BG: ;
        default:     ;
      endcase
    end
  end

  always_comb begin
    if (columns == 8'd0)
      dims.width = 8'd1;
    else if ({1'b0, columns} > 9'(MAX_COLS))
      dims.width = 8'(MAX_COLS);
    else
      dims.width = columns;

    if (rows == 7'd0)
      dims.height = 7'd1;
    else if ({2'b00, rows} > 9'(MAX_ROWS))
      dims.height = 7'(MAX_ROWS);
    else
      dims.height = rows;

    dims.dflt_fg = dflt_fg;
  end

endmodule

// ===== rtl/core/acte_engine.sv =====
// Cursor, colour and escape-parser state with its single-pass update.
`timescale 1ns / 1ps
module acte_engine #(
  parameter int MAX_COLS = acte_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = acte_pkg::MAX_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        char_code,
  input  acte_pkg::dims_t   dims,
  output acte_pkg::result_t result
);
  import acte_pkg::*;

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [1:0]       phase, phase_next;
  logic [1:0]       param_count, param_count_next;
  logic [7:0]       param0, param0_next;
  logic [7:0]       param1, param1_next;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic [3:0]       current_fg, fg_next;
  logic [3:0]       current_bg, bg_next;

  logic [7:0] col_cl, col_n, row_cl, row_n, height8;
  logic       sgr_fg, sgr_bg, handled, digit_ok;
  logic [7:0] digit;
  logic [3:0] pal;

  always_comb begin
    height8 = {1'b0, dims.height};
    // screen may have shrunk since the cursor was set
    col_cl = (8'(cursor_col) >= dims.width) ? dims.width - 8'd1 : 8'(cursor_col);
    row_cl = (8'(cursor_row) >= height8) ? height8 - 8'd1 : 8'(cursor_row);

    sgr_fg   = (char_code == CH_SGR) && (param_count == PARAMS_FULL) && (param0 == CH_THREE);
    sgr_bg   = (char_code == CH_SGR) && (param_count == PARAMS_FULL) && (param0 == CH_FOUR);
    handled  = (char_code == CH_UP) || (char_code == CH_DOWN) || (char_code == CH_RIGHT) ||
               (char_code == CH_LEFT) || sgr_fg || sgr_bg;
    digit    = param1 - CH_ZERO;
    digit_ok = (param1 >= CH_ZERO) && (param1 <= CH_NINE);
    pal      = palette_lookup(digit[3:0]);

    phase_next       = phase;
    param_count_next = param_count;
    param0_next      = param0;
    param1_next      = param1;
    fg_next          = current_fg;
    bg_next          = current_bg;
    col_n            = col_cl;
    row_n            = row_cl;
    result           = '0;

    unique case (phase)
      PH_ESC: begin
        if (char_code == CH_LBRACKET) begin
          phase_next       = PH_CSI;
          param_count_next = 2'd0;
        end else begin
          phase_next = PH_TEXT;
        end
      end
      PH_CSI: begin
        if (char_code == CH_UP) begin
          if (row_cl != 8'd0) row_n = row_cl - 8'd1;
        end else if (char_code == CH_DOWN) begin
          if (row_cl + 8'd1 < height8) row_n = row_cl + 8'd1;
        end else if (char_code == CH_RIGHT) begin
          if (col_cl + 8'd1 < dims.width) col_n = col_cl + 8'd1;
        end else if (char_code == CH_LEFT) begin
          if (col_cl != 8'd0) col_n = col_cl - 8'd1;
        end else if (sgr_fg) begin
          if (digit_ok) fg_next = (digit[3:0] == DIGIT_DEFAULT_FG) ? dims.dflt_fg : pal;
        end else if (sgr_bg) begin
          if (digit_ok) bg_next = pal;
        end

        if (handled) begin
          phase_next = PH_TEXT;
        end else if (param_count < PARAMS_FULL) begin
          if (param_count[0]) param1_next = char_code;
          else param0_next = char_code;
          param_count_next = param_count + 2'd1;
        end else begin
          phase_next = PH_TEXT;
        end
      end
      default: begin
        // normal text (the unused phase code behaves the same)
        if (char_code == CH_ESC) begin
          phase_next = PH_ESC;
        end else if (char_code == CH_CR) begin
          col_n = 8'd0;
        end else if (char_code == CH_LF) begin
          row_n = row_cl + 8'd1;
        end else if (char_code == CH_BS) begin
          if (col_cl != 8'd0) col_n = col_cl - 8'd1;
          result.draw_valid = 1'b1;
          result.cell_col   = col_n[6:0];
          result.cell_row   = row_cl[5:0];
          result.glyph      = CH_SPACE;
          result.draw_fg    = current_fg;
          result.draw_bg    = current_bg;
        end else begin
          result.draw_valid = 1'b1;
          result.cell_col   = col_cl[6:0];
          result.cell_row   = row_cl[5:0];
          result.glyph      = char_code;
          result.draw_fg    = current_fg;
          result.draw_bg    = current_bg;
          if (col_cl + 8'd1 >= dims.width) begin
            col_n = 8'd0;
            row_n = row_cl + 8'd1;
          end else begin
            col_n = col_cl + 8'd1;
          end
        end
      end
    endcase

    if (row_n >= height8) begin
      result.scroll_up = 1'b1;
      row_n            = height8 - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TEXT;
      param_count <= 2'd0;
      param0      <= 8'd0;
      param1      <= 8'd0;
      cursor_col  <= '0;
      cursor_row  <= '0;
      current_fg  <= DFLT_FG_RST;
      current_bg  <= INIT_BG_RST;
    end else if (step) begin
      phase       <= phase_next;
      param_count <= param_count_next;
      param0      <= param0_next;
      param1      <= param1_next;
      cursor_col  <= col_n[COL_W-1:0];
      cursor_row  <= row_n[ROW_W-1:0];
      current_fg  <= fg_next;
      current_bg  <= bg_next;
    end
  end

endmodule

// ===== rtl/core/ansi_terminal_char_engine_core.sv =====
// Terminal character engine: one character word in, one draw/scroll word out.
// Latency: a character accepted at one edge is registered into the result word at the next
// edge where the result register is free or being emptied, and is offered from that edge.
// Throughput: one character per cycle; input is held off only while both the input and the
// result register are full and the result word is not taken.
// Reset (synchronous): parser to normal text, cursor home, colours and configuration registers to reset values.
`timescale 1ns / 1ps
`include "ansi_terminal_char_engine_core_assert.svh"
module ansi_terminal_char_engine_core #(
  parameter int MAX_COLS = acte_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = acte_pkg::MAX_ROWS_DEF
) (
  input logic         clk,
  input logic         rst,
  acte_chr_if.sink    chr,
  acte_res_if.source  res,
  acte_cfg_if.sink    cfg
);
  import acte_pkg::*;

  logic       in_full;
  logic [7:0] in_char;
  logic       out_full;
  logic       advance;
  dims_t      dims;
  result_t    step_res;
  result_t    out_res;

  assign advance   = in_full && (!out_full || res.ready);
  assign chr.ready = !in_full || advance;
  assign cfg.ready = 1'b1;

  acte_cfg_regs #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .dims     (dims)
  );

  acte_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_code (in_char),
    .dims      (dims),
    .result    (step_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (chr.valid && chr.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chr.valid && chr.ready) in_char <= chr.char_code;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (res.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= step_res;
  end

  assign res.valid      = out_full;
  assign res.draw_valid = out_res.draw_valid;
  assign res.cell_col   = out_res.cell_col;
  assign res.cell_row   = out_res.cell_row;
  assign res.glyph      = out_res.glyph;
  assign res.draw_fg    = out_res.draw_fg;
  assign res.draw_bg    = out_res.draw_bg;
  assign res.scroll_up  = out_res.scroll_up;

  `ACTE_ASSERT_NXT(a_step_gives_word, advance, out_full)
  `ACTE_ASSERT_IMP(a_full_stall_blocks_input, in_full && out_full && !res.ready, !chr.ready)
  `ACTE_ASSERT_IMP(a_no_draw_fields_zero, out_full && !out_res.draw_valid,
                   out_res.cell_col == 7'd0 && out_res.cell_row == 6'd0 &&
                   out_res.glyph == 8'd0 && out_res.draw_fg == 4'd0 &&
                   out_res.draw_bg == 4'd0)

endmodule

// ===== dv/ansi_terminal_char_engine_core_tb.sv =====
// Self-checking testbench for the terminal character engine: a directed sequence, then random text and escape streams.
`timescale 1ns / 1ps
module ansi_terminal_char_engine_core_tb;
  import acte_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // well above the longest deliberate result stall, HOLD_CYCLES
  localparam int HOLD_CYCLES = 200;

  localparam logic [7:0] DIRECTED [26] = '{
    8'h00, 8'hFF, CH_BS, CH_CR, CH_LF,
    CH_ESC, CH_LBRACKET, CH_THREE, 8'h31, CH_SGR,
    8'h78,
    CH_ESC, CH_LBRACKET, CH_FOUR, 8'h37, CH_SGR,
    CH_ESC, CH_LBRACKET, CH_THREE, 8'h37, CH_SGR,
    CH_ESC, CH_LBRACKET, CH_DOWN,
    CH_ESC, 8'h51
  };

  // Tracks cursor, colours and parser; holds the draw/scroll words still to come.
  class terminal_shadow;
    logic [7:0] cols_reg;
    logic [6:0] rows_reg;
    logic [3:0] dflt_fg;
    logic [3:0] init_bg;
    logic [1:0] phase;
    logic [1:0] nparams;
    logic [7:0] params [2];
    logic [7:0] col;
    logic [6:0] row;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [3:0] colour_of_digit [10];
    result_t    draws_due [$];
    int         mismatches;
    int         orphans;
    int         reported;
    int         draws;
    int         scrolls;

    function new();
      cols_reg = COLUMNS_RST;
      rows_reg = ROWS_RST;
      dflt_fg = DFLT_FG_RST;
      init_bg = INIT_BG_RST;
      phase = PH_TEXT;
      nparams = '0;
      params[0] = '0;
      params[1] = '0;
      col = '0;
      row = '0;
      fg = dflt_fg;
      bg = init_bg;
      colour_of_digit = '{4'd0, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd8, 4'd15, 4'd0};
      mismatches = 0;
      orphans = 0;
      reported = 0;
      draws = 0;
      scrolls = 0;
    endfunction

    function void set_reg(logic [3:0] idx, logic [7:0] data);
      case (idx)
        REG_COLUMNS: cols_reg = data;
        REG_ROWS:    rows_reg = data[6:0];
        REG_DFLT_FG: dflt_fg = data[3:0];
        REG_INIT_BG: init_bg = data[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned fit(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // non-digit second byte leaves the colour alone
    function void apply_colour(bit fore, logic [7:0] b);
      int unsigned d;
      if (b < CH_ZERO || b > CH_NINE) return;
      d = b - CH_ZERO;
      if (fore) fg = (d == DIGIT_DEFAULT_FG) ? dflt_fg : colour_of_digit[d];
      else bg = colour_of_digit[d];
    endfunction

    function void take_char(logic [7:0] ch);
      int unsigned wc;
      int unsigned hc;
      bit          handled;
      result_t     r;
      wc = fit(cols_reg, MAX_COLS_DEF);
      hc = fit(rows_reg, MAX_ROWS_DEF);
      r = '0;
      handled = 1'b1;
      // screen may have shrunk since the last word
      if (col >= wc) col = 8'(wc - 1);
      if (row >= hc) row = 7'(hc - 1);
      case (phase)
        PH_ESC: begin
          if (ch == CH_LBRACKET) begin
            phase = PH_CSI;
            nparams = '0;
          end else begin
            phase = PH_TEXT;
          end
        end
        PH_CSI: begin
          if (ch == CH_UP) begin
            if (row > 0) row--;
          end else if (ch == CH_DOWN) begin
            if (row + 1 < hc) row++;
          end else if (ch == CH_RIGHT) begin
            if (col + 1 < wc) col++;
          end else if (ch == CH_LEFT) begin
            if (col > 0) col--;
          end else if (ch == CH_SGR && nparams == PARAMS_FULL && params[0] == CH_THREE) begin
            apply_colour(1'b1, params[1]);
          end else if (ch == CH_SGR && nparams == PARAMS_FULL && params[0] == CH_FOUR) begin
            apply_colour(1'b0, params[1]);
          end else begin
            handled = 1'b0;
          end
          if (handled) begin
            phase = PH_TEXT;
          end else if (nparams < PARAMS_FULL) begin
            params[nparams[0]] = ch;
            nparams++;
          end else begin
            phase = PH_TEXT;
          end
        end
        default: begin
          if (ch == CH_ESC) begin
            phase = PH_ESC;
          end else if (ch == CH_CR) begin
            col = '0;
          end else if (ch == CH_LF) begin
            row++;
          end else if (ch == CH_BS) begin
            if (col > 0) col--;
            r.draw_valid = 1'b1;
            r.cell_col = col[6:0];
            r.cell_row = row[5:0];
            r.glyph = CH_SPACE;
            r.draw_fg = fg;
            r.draw_bg = bg;
          end else begin
            r.draw_valid = 1'b1;
            r.cell_col = col[6:0];
            r.cell_row = row[5:0];
            r.glyph = ch;
            r.draw_fg = fg;
            r.draw_bg = bg;
            col++;
            if (col >= wc) begin
              col = '0;
              row++;
            end
          end
        end
      endcase
      if (row >= hc) begin
        r.scroll_up = 1'b1;
        row = 7'(hc - 1);
      end
      draws_due.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf("draw=%0d col=%0d row=%0d glyph=%02h fg=%0d bg=%0d scroll=%0d",
                       r.draw_valid, r.cell_col, r.cell_row, r.glyph, r.draw_fg,
                       r.draw_bg, r.scroll_up);
    endfunction

    function void check_word(result_t got);
      result_t want;
      string   diff;
      if (draws_due.size() == 0) begin
        orphans++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result word: %s", show(got));
        end
        return;
      end
      want = draws_due.pop_front();
      diff = "";
      if (got.draw_valid !== want.draw_valid) diff = {diff, " draw_valid"};
      if (got.cell_col !== want.cell_col) diff = {diff, " cell_col"};
      if (got.cell_row !== want.cell_row) diff = {diff, " cell_row"};
      if (got.glyph !== want.glyph) diff = {diff, " glyph"};
      if (got.draw_fg !== want.draw_fg) diff = {diff, " draw_fg"};
      if (got.draw_bg !== want.draw_bg) diff = {diff, " draw_bg"};
      if (got.scroll_up !== want.scroll_up) diff = {diff, " scroll_up"};
      if (want.draw_valid) draws++;
      if (want.scroll_up) scrolls++;
      if (diff != "") begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("mismatch at %0t in%s", $realtime, diff);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  acte_chr_if chr_if();
  acte_res_if res_if();
  acte_cfg_if cfg_if();

  ansi_terminal_char_engine_core i_dut (
    .clk (clk),
    .rst (rst),
    .chr (chr_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  terminal_shadow shadow;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_left;
  int n_chars;
  int n_settings;
  int quiet_cycles;

  always #5 clk = ~clk;

  // result side: random stalls, or a long hold when asked
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        res_if.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = '{draw_valid: res_if.draw_valid, cell_col: res_if.cell_col,
              cell_row: res_if.cell_row, glyph: res_if.glyph, draw_fg: res_if.draw_fg,
              draw_bg: res_if.draw_bg, scroll_up: res_if.scroll_up};
      shadow.check_word(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (chr_if.valid && chr_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no progress for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // valid is left high after acceptance; the next word or settle() changes it
  task automatic push_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      chr_if.valid = 1'b0;
      @(negedge clk);
    end
    chr_if.valid = 1'b1;
    chr_if.char_code = c;
    do @(posedge clk); while (!chr_if.ready);
    shadow.take_char(c);
    n_chars++;
  endtask

  task automatic settle();
    @(negedge clk);
    chr_if.valid = 1'b0;
    while (shadow.draws_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = data;
    do @(posedge clk); while (!cfg_if.ready);
    shadow.set_reg(idx, data);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic reconfigure(input logic [7:0] cols, input logic [6:0] rws,
                             input logic [3:0] dfg, input logic [3:0] ibg);
    settle();
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, {1'b0, rws});
    write_reg(REG_DFLT_FG, {4'h0, dfg});
    write_reg(REG_INIT_BG, {4'h0, ibg});
    n_settings++;
  endtask

  // one burst: mostly well-formed text and escapes, some broken sequences and noise
  function automatic void build_burst(ref logic [7:0] seq[$]);
    int kind;
    int len;
    seq.delete();
    kind = $urandom_range(99);
    if (kind < 30) begin
      len = $urandom_range(8, 1);
      repeat (len) begin
        seq.push_back(($urandom_range(9) < 7) ? 8'($urandom_range(126, 32))
                                              : 8'($urandom_range(255)));
      end
    end else if (kind < 45) begin
      seq = '{CH_ESC, CH_LBRACKET, 8'(CH_UP + $urandom_range(3))};
    end else if (kind < 62) begin
      seq = '{CH_ESC, CH_LBRACKET,
              ($urandom_range(9) < 9) ? ($urandom_range(1) ? CH_THREE : CH_FOUR)
                                      : 8'($urandom_range(255)),
              ($urandom_range(9) < 8) ? 8'(CH_ZERO + $urandom_range(9))
                                      : 8'($urandom_range(255)),
              ($urandom_range(19) < 19) ? CH_SGR : 8'($urandom_range(255))};
    end else if (kind < 75) begin
      case ($urandom_range(2))
        0: seq.push_back(CH_BS);
        1: seq.push_back(CH_CR);
        default: seq.push_back(CH_LF);
      endcase
    end else if (kind < 88) begin
      case ($urandom_range(3))
        0: seq = '{CH_ESC, 8'($urandom_range(255))};
        1: begin
          seq = '{CH_ESC, CH_LBRACKET};
          len = $urandom_range(3, 1);
          repeat (len) seq.push_back(8'($urandom_range(255)));
        end
        2: seq = '{CH_ESC, CH_LBRACKET, CH_SGR, CH_SGR, CH_SGR};
        default: seq = '{CH_ESC, CH_LBRACKET, 8'(CH_ZERO + $urandom_range(2)),
                         8'(CH_ZERO + $urandom_range(9)), CH_SGR};
      endcase
    end else begin
      seq.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic run_text(input int n);
    logic [7:0] seq [$];
    int stop_at;
    stop_at = n_chars + n;
    while (n_chars < stop_at) begin
      build_burst(seq);
      foreach (seq[i]) push_char(seq[i]);
    end
  endtask

  initial begin
    int failures;
    chr_if.valid = 1'b0;
    chr_if.char_code = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_COLUMNS;
    cfg_if.data = '0;
    rst = 1'b1;
    shadow = new();
    src_idle_pct = 17;
    snk_idle_pct = 79;
    hold_left = 0;
    n_chars = 0;
    n_settings = 1;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i]) push_char(DIRECTED[i]);
    run_text(180);
    reconfigure(8'd128, 7'd64, 4'd15, 4'd0);
    run_text(150);
    reconfigure(8'd5, 7'd3, 4'd9, 4'd2);
    run_text(150);

    src_idle_pct = 79;
    snk_idle_pct = 17;
    reconfigure(8'd1, 7'd1, 4'd0, 4'd15);
    run_text(120);
    reconfigure(8'd255, 7'd127, 4'd7, 4'd9);
    run_text(150);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    reconfigure(8'd0, 7'd0, 4'd3, 4'd4);
    run_text(140);
    reconfigure(8'($urandom_range(128, 1)), 7'($urandom_range(64, 1)),
                4'($urandom_range(15)), 4'($urandom_range(15)));
    // result side blocked while text keeps coming, so the input backs up
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    run_text(170);
    reconfigure(8'd20, 7'd6, 4'd12, 4'd1);
    run_text(150);

    settle();
    repeat (10) @(posedge clk);

    failures = shadow.mismatches + shadow.orphans + shadow.draws_due.size();
    $display("Sent %0d characters over %0d screen settings, with stalls on both sides.",
             n_chars, n_settings);
    $display("Seen %0d glyph draws and %0d scrolls; %0d bad words, %0d unexpected, %0d missing.",
             shadow.draws, shadow.scrolls, shadow.mismatches, shadow.orphans,
             shadow.draws_due.size());
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/acte_pkg.sv
rtl/core/acte_chr_if.sv
rtl/core/acte_res_if.sv
rtl/core/acte_cfg_if.sv
rtl/core/acte_cfg_regs.sv
rtl/core/acte_engine.sv
rtl/core/ansi_terminal_char_engine_core.sv
dv/ansi_terminal_char_engine_core_tb.sv
